// ===== rtl/core/scc_pkg.sv =====
// Shared types, constants and helpers for the spike cross-correlogram block.
package scc_pkg;

  localparam int SCC_CHANNELS   = 64;
  localparam int SCC_MAX_BINS   = 64;
  localparam int SCC_RING_DEPTH = 16;

  localparam int BIN_WIDTH_W = 16;
  localparam int BIN_COUNT_W = 7;

  localparam logic [15:0] BIN_WIDTH_RST = 16'd1;
  localparam logic [6:0]  BIN_COUNT_RST = 7'd64;

  // configuration register indexes
  localparam logic CFG_BIN_WIDTH = 1'b0;
  localparam logic CFG_BIN_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ACT_SPIKE = 2'd0,
    ACT_BIN   = 2'd1,
    ACT_TOTAL = 2'd2,
    ACT_SPAN  = 2'd3
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [5:0]  channel;
    logic [31:0] spike_time;
    logic [5:0]  ref_channel;
    logic [5:0]  bin_index;
  } scc_in_t;

  typedef struct packed {
    logic [31:0] value;
    logic        ring_overflow;
  } scc_out_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    sat_inc = (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

endpackage

// ===== rtl/core/scc_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module scc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/scc_lag_div.sv =====
// Restoring divider, one quotient bit per cycle: lag / bin width -> bin.
module scc_lag_div
  import scc_pkg::*;
#(
  parameter int QW   = 6,
  parameter int WINW = 22
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WINW-1:0]  dividend,
  input  logic [15:0]      divisor,
  output logic             done,
  output logic [QW-1:0]    quotient
);

  localparam int SCW = $clog2(QW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [WINW-1:0] rem_r, rem_nxt;
  logic [WINW-1:0] dsr_r, dsr_nxt;
  logic [QW-1:0]   q_r, q_nxt;
  logic [SCW-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = dividend;
      dsr_nxt  = WINW'(divisor) << (QW - 1);
      cnt_nxt  = SCW'(QW - 1);
    end else if (busy_r) begin
      if (rem_r >= dsr_r) begin
        rem_nxt = rem_r - dsr_r;
        q_nxt   = {q_r[QW-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[QW-2:0], 1'b0};
      end
      dsr_nxt = dsr_r >> 1;
      cnt_nxt = cnt_r - SCW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/core/spike_cross_correlogram.sv =====
// Spike cross-correlogram builder: top level with sequencer and stores.
//
//  channel | handshake          | payload   | direction
//  --------+--------------------+-----------+----------
//  in      | in_valid/in_stall  | scc_in_t  | into block
//  out     | out_valid/out_stall| scc_out_t | out of block
//  cfg     | cfg_we             | cfg_index, cfg_wdata | into block
//
// After reset a clearing pass writes zero to every histogram bin (and the
// channel totals and ring pointers) at one entry per cycle, with in_stall high;
// there are CHANNELS*CHANNELS*MAX_BINS bins (262144 by default). Reads pass
// through PUT (span), TOTR_RD, RD_DATA, PUT (channel total) or BIN_ROW, BIN_BASE,
// BIN_RD, RD_DATA, PUT (histogram bin). A spike bumps its channel total, reads
// every stored time of every ring and, for one in the lag window, divides the lag
// (QW = log2 MAX_BINS quotient bits) and bumps a bin, then pushes into its own
// ring; the bit-serial divider and the single read port of each store serialise it.
// A finished result waits in the output register under out_stall while the
// next item is already taken.
module spike_cross_correlogram
  import scc_pkg::*;
#(
  parameter int CHANNELS   = SCC_CHANNELS,
  parameter int MAX_BINS   = SCC_MAX_BINS,
  parameter int RING_DEPTH = SCC_RING_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  scc_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output scc_out_t    out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int HDEPTH = CHANNELS * CHANNELS * MAX_BINS;
  localparam int HAW    = $clog2(HDEPTH);
  localparam int TDEPTH = CHANNELS * RING_DEPTH;
  localparam int TAW    = $clog2(TDEPTH);
  localparam int CHW    = $clog2(CHANNELS);
  localparam int QW     = $clog2(MAX_BINS);
  localparam int FW     = $clog2(RING_DEPTH + 1);
  localparam int HW     = $clog2(RING_DEPTH);
  localparam int MW     = FW + HW;
  localparam int CNTW   = $clog2(MAX_BINS + 1);
  localparam int WINW   = BIN_WIDTH_W + QW;

  typedef enum logic [20:0] {
    S_CLEAR     = 21'b1 << 0,
    S_IDLE      = 21'b1 << 1,
    S_TOT_RD    = 21'b1 << 2,
    S_TOT_WR    = 21'b1 << 3,
    S_META_RD   = 21'b1 << 4,
    S_META_USE  = 21'b1 << 5,
    S_TIME_RD   = 21'b1 << 6,
    S_TIME_CHK  = 21'b1 << 7,
    S_DIV       = 21'b1 << 8,
    S_HIST_RD   = 21'b1 << 9,
    S_HIST_WR   = 21'b1 << 10,
    S_PUSH_RD   = 21'b1 << 11,
    S_PUSH_META = 21'b1 << 12,
    S_PUSH_TRD  = 21'b1 << 13,
    S_PUSH_WR   = 21'b1 << 14,
    S_BIN_ROW   = 21'b1 << 15,
    S_BIN_BASE  = 21'b1 << 16,
    S_BIN_RD    = 21'b1 << 17,
    S_TOTR_RD   = 21'b1 << 18,
    S_RD_DATA   = 21'b1 << 19,
    S_PUT       = 21'b1 << 20
  } state_t;

  // config
  logic [15:0] bin_width_r;
  logic [6:0]  bin_count_r;

  // sequencer
  state_t          state_r, state_nxt;
  logic [HAW-1:0]  clr_r, clr_nxt;
  scc_in_t         item_r, item_nxt;
  logic [CHW-1:0]  ch_r, ch_nxt;
  logic [CHW-1:0]  r_r, r_nxt;
  logic [FW-1:0]   k_r, k_nxt;
  logic [HW-1:0]   slot_r, slot_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [HW-1:0]   head_r, head_nxt;
  logic [HAW-1:0]  row_r, row_nxt;
  logic [HAW-1:0]  base_r, base_nxt;
  logic [TAW-1:0]  tbase_r, tbase_nxt;
  logic [WINW-1:0] win_r, win_nxt;
  logic [31:0]     first_r, first_nxt;
  logic [31:0]     last_r, last_nxt;
  logic            seen_r, seen_nxt;
  logic [31:0]     res_val_r, res_val_nxt;
  logic            res_ovf_r, res_ovf_nxt;
  logic            out_valid_r, out_valid_nxt;
  scc_out_t        out_data_r, out_data_nxt;

  // store ports
  logic           hist_we, tot_we, meta_we, time_we;
  logic [HAW-1:0] hist_addr, hist_waddr;
  logic [31:0]    hist_wdata, hist_rdata;
  logic [CHW-1:0] tot_waddr, meta_waddr, meta_raddr;
  logic [31:0]    tot_wdata, tot_rdata;
  logic [MW-1:0]  meta_wdata, meta_rdata;
  logic [TAW-1:0] time_addr;
  logic [31:0]    time_rdata;

  // divider
  logic          div_start, div_done;
  logic [QW-1:0] div_q;

  // datapath helpers
  logic [15:0]     w_eff;
  logic [CNTW-1:0] cnt_eff;
  logic [FW-1:0]   meta_fill;
  logic [HW-1:0]   meta_head;
  logic [FW:0]     st_sum;
  logic [HW-1:0]   st_slot;
  logic [HW-1:0]   slot_inc;
  logic [HW-1:0]   head_inc;
  logic [31:0]     lag;
  logic            in_win;
  logic [QW-1:0]   bin_sel;
  logic [CHW-1:0]  row_sel;
  logic            clr_low;
  logic            ch_ok, rc_ok, bi_ok;

  assign w_eff   = (bin_width_r == '0) ? 16'd1 : bin_width_r;
  assign cnt_eff = (32'(bin_count_r) > 32'(MAX_BINS)) ? CNTW'(MAX_BINS) : CNTW'(bin_count_r);

  assign meta_fill = meta_rdata[MW-1:HW];
  assign meta_head = meta_rdata[HW-1:0];

  // oldest slot = head - fill, modulo ring depth
  assign st_sum  = (FW+1)'(meta_head) + (FW+1)'(RING_DEPTH) - (FW+1)'(meta_fill);
  assign st_slot = (st_sum >= (FW+1)'(RING_DEPTH)) ? HW'(st_sum - (FW+1)'(RING_DEPTH))
                                                   : HW'(st_sum);
  assign slot_inc = (slot_r == HW'(RING_DEPTH - 1)) ? '0 : slot_r + HW'(1);
  assign head_inc = (head_r == HW'(RING_DEPTH - 1)) ? '0 : head_r + HW'(1);

  // shared lag compare: stored time against now, for binning and overflow
  assign lag    = item_r.spike_time - time_rdata;
  assign in_win = (time_rdata <= item_r.spike_time) && (lag < 32'(win_r));

  assign bin_sel = (state_r == S_BIN_RD) ? QW'(item_r.bin_index) : div_q;
  assign row_sel = (state_r == S_BIN_ROW) ? CHW'(item_r.ref_channel) : r_r;

  assign hist_addr = base_r + HAW'(bin_sel);
  assign clr_low   = (clr_r < HAW'(CHANNELS));

  assign ch_ok = 32'(in_data.channel) < 32'(CHANNELS);
  assign rc_ok = 32'(in_data.ref_channel) < 32'(CHANNELS);
  assign bi_ok = 32'(in_data.bin_index) < 32'(MAX_BINS);

  // store write ports, read addresses and divider start
  always_comb begin
    hist_we    = (state_r == S_CLEAR) || (state_r == S_HIST_WR);
    hist_waddr = (state_r == S_CLEAR) ? clr_r : hist_addr;
    hist_wdata = (state_r == S_CLEAR) ? 32'd0 : sat_inc(hist_rdata);

    tot_we    = ((state_r == S_CLEAR) && clr_low) || (state_r == S_TOT_WR);
    tot_waddr = (state_r == S_CLEAR) ? CHW'(clr_r) : ch_r;
    tot_wdata = (state_r == S_CLEAR) ? 32'd0 : sat_inc(tot_rdata);

    meta_we    = ((state_r == S_CLEAR) && clr_low) || (state_r == S_PUSH_WR);
    meta_waddr = (state_r == S_CLEAR) ? CHW'(clr_r) : ch_r;
    if (state_r == S_CLEAR) begin
      meta_wdata = '0;
    end else if (fill_r == FW'(RING_DEPTH)) begin
      meta_wdata = {fill_r, head_inc};
    end else begin
      meta_wdata = {fill_r + FW'(1), head_inc};
    end
    meta_raddr = (state_r == S_PUSH_RD) ? ch_r : r_r;

    time_we   = (state_r == S_PUSH_WR);
    time_addr = tbase_r + TAW'(slot_r);

    div_start = (state_r == S_TIME_CHK) && in_win;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    item_nxt      = item_r;
    ch_nxt        = ch_r;
    r_nxt         = r_r;
    k_nxt         = k_r;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    head_nxt      = head_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    tbase_nxt     = tbase_r;
    win_nxt       = win_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    seen_nxt      = seen_r;
    res_val_nxt   = res_val_r;
    res_ovf_nxt   = res_ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + HAW'(1);
        if (clr_r == HAW'(HDEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt    = in_data;
          ch_nxt      = CHW'(in_data.channel);
          res_val_nxt = 32'd0;
          res_ovf_nxt = 1'b0;
          state_nxt   = S_PUT;
          unique case (in_data.action)
            ACT_SPIKE: begin
              if (ch_ok) begin
                if (!seen_r) begin
                  first_nxt = in_data.spike_time;
                end
                seen_nxt  = 1'b1;
                last_nxt  = in_data.spike_time;
                state_nxt = S_TOT_RD;
              end
            end
            ACT_BIN: begin
              if (ch_ok && rc_ok && bi_ok) begin
                state_nxt = S_BIN_ROW;
              end
            end
            ACT_TOTAL: begin
              if (ch_ok) begin
                state_nxt = S_TOTR_RD;
              end
            end
            ACT_SPAN: begin
              res_val_nxt = seen_r ? last_r - first_r : 32'd0;
            end
            default: ;
          endcase
        end
      end
      S_TOT_RD: begin
        win_nxt   = WINW'(w_eff) * WINW'(cnt_eff);
        state_nxt = S_TOT_WR;
      end
      S_TOT_WR: begin
        r_nxt     = '0;
        state_nxt = S_META_RD;
      end
      S_META_RD: begin
        row_nxt   = HAW'(HAW'(row_sel) * HAW'(CHANNELS)) + HAW'(ch_r);
        tbase_nxt = TAW'(TAW'(r_r) * TAW'(RING_DEPTH));
        state_nxt = S_META_USE;
      end
      S_META_USE: begin
        fill_nxt = meta_fill;
        base_nxt = HAW'(row_r * HAW'(MAX_BINS));
        k_nxt    = '0;
        slot_nxt = st_slot;
        if (meta_fill != '0) begin
          state_nxt = S_TIME_RD;
        end else if (r_r == CHW'(CHANNELS - 1)) begin
          state_nxt = S_PUSH_RD;
        end else begin
          r_nxt     = r_r + CHW'(1);
          state_nxt = S_META_RD;
        end
      end
      S_TIME_RD: begin
        state_nxt = S_TIME_CHK;
      end
      S_TIME_CHK, S_HIST_WR: begin
        if ((state_r == S_TIME_CHK) && in_win) begin
          state_nxt = S_DIV;
        end else if (k_r + FW'(1) != fill_r) begin
          k_nxt     = k_r + FW'(1);
          slot_nxt  = slot_inc;
          state_nxt = S_TIME_RD;
        end else if (r_r == CHW'(CHANNELS - 1)) begin
          state_nxt = S_PUSH_RD;
        end else begin
          r_nxt     = r_r + CHW'(1);
          state_nxt = S_META_RD;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_HIST_RD;
        end
      end
      S_HIST_RD: begin
        state_nxt = S_HIST_WR;
      end
      S_PUSH_RD: begin
        tbase_nxt = TAW'(TAW'(ch_r) * TAW'(RING_DEPTH));
        state_nxt = S_PUSH_META;
      end
      S_PUSH_META: begin
        fill_nxt  = meta_fill;
        head_nxt  = meta_head;
        slot_nxt  = meta_head;
        state_nxt = S_PUSH_TRD;
      end
      S_PUSH_TRD: begin
        state_nxt = S_PUSH_WR;
      end
      S_PUSH_WR: begin
        res_ovf_nxt = (fill_r == FW'(RING_DEPTH)) && in_win;
        state_nxt   = S_PUT;
      end
      S_BIN_ROW: begin
        row_nxt   = HAW'(HAW'(row_sel) * HAW'(CHANNELS)) + HAW'(ch_r);
        state_nxt = S_BIN_BASE;
      end
      S_BIN_BASE: begin
        base_nxt  = HAW'(row_r * HAW'(MAX_BINS));
        state_nxt = S_BIN_RD;
      end
      S_BIN_RD, S_TOTR_RD: begin
        state_nxt = S_RD_DATA;
      end
      S_RD_DATA: begin
        res_val_nxt = (item_r.action == ACT_BIN) ? hist_rdata : tot_rdata;
        state_nxt   = S_PUT;
      end
      S_PUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.value         = res_val_r;
          out_data_nxt.ring_overflow = res_ovf_r;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      first_r     <= '0;
      last_r      <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
      bin_width_r <= BIN_WIDTH_RST;
      bin_count_r <= BIN_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_BIN_WIDTH) begin
          bin_width_r <= cfg_wdata;
        end else begin
          bin_count_r <= cfg_wdata[BIN_COUNT_W-1:0];
        end
      end
    end
    item_r     <= item_nxt;
    ch_r       <= ch_nxt;
    r_r        <= r_nxt;
    k_r        <= k_nxt;
    slot_r     <= slot_nxt;
    fill_r     <= fill_nxt;
    head_r     <= head_nxt;
    row_r      <= row_nxt;
    base_r     <= base_nxt;
    tbase_r    <= tbase_nxt;
    win_r      <= win_nxt;
    res_val_r  <= res_val_nxt;
    res_ovf_r  <= res_ovf_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // stores
  scc_ram #(.WIDTH(32), .DEPTH(HDEPTH)) u_hist (
    .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(hist_wdata),
    .raddr(hist_addr), .rdata(hist_rdata)
  );

  scc_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_tot (
    .clk(clk), .we(tot_we), .waddr(tot_waddr), .wdata(tot_wdata),
    .raddr(ch_r), .rdata(tot_rdata)
  );

  scc_ram #(.WIDTH(MW), .DEPTH(CHANNELS)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(meta_raddr), .rdata(meta_rdata)
  );

  scc_ram #(.WIDTH(32), .DEPTH(TDEPTH)) u_time (
    .clk(clk), .we(time_we), .waddr(time_addr), .wdata(item_r.spike_time),
    .raddr(time_addr), .rdata(time_rdata)
  );

  scc_lag_div #(.QW(QW), .WINW(WINW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(WINW'(lag)),
    .divisor(w_eff), .done(div_done), .quotient(div_q)
  );

endmodule

// ===== rtl/core/scc_checker.sv =====
// Port-level checks for the spike cross-correlogram, bound to the top level.
module scc_checker
  import scc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input scc_in_t     in_data,
  input logic        out_valid,
  input logic        out_stall,
  input scc_out_t    out_data,
  input logic        cfg_we,
  input logic        cfg_index,
  input logic [15:0] cfg_wdata
);

  // a held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // one item at a time: a taken beat makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item in progress");

  // reset starts the clearing pass with no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("block not clearing after reset");

  // an offered beat carries known fields
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_data))
    else $error("unknown input beat");

  // register writes land only on an idle block
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !in_stall && !out_valid && !$isunknown({cfg_index, cfg_wdata}))
    else $error("register write while busy");

endmodule

bind spike_cross_correlogram scc_checker u_scc_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking bench for the spike cross-correlogram block: stimulus, scoreboard, idling.
module tb_top
  import scc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH   = SCC_CHANNELS;
  localparam int NBINS = SCC_MAX_BINS;
  localparam int DEPTH = SCC_RING_DEPTH;
  // quiet cycles tolerated: clearing pass plus worst spike with margin
  localparam int QUIET_LIMIT = 1100000;

  // Scoreboard: a software copy of the correlogram state and a queue of
  // the beats the block owes us.
  class correlogram_sb;
    logic [31:0] hist_cnt [NCH*NCH*NBINS];
    logic [31:0] totals [NCH];
    logic [31:0] ring_times [NCH*DEPTH];
    int          fill [NCH];
    int          head [NCH];
    logic [31:0] t_first, t_last;
    bit          any_spike;
    logic [15:0] width_reg;
    logic [6:0]  count_reg;
    scc_out_t    owed [$];
    int          errors;

    function void clear();
      foreach (hist_cnt[i]) hist_cnt[i] = '0;
      foreach (totals[i]) totals[i] = '0;
      foreach (fill[i]) begin
        fill[i] = 0;
        head[i] = 0;
      end
      t_first = '0;
      t_last = '0;
      any_spike = 0;
      width_reg = BIN_WIDTH_RST;
      count_reg = BIN_COUNT_RST;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] v);
      if (idx == CFG_BIN_WIDTH) width_reg = v;
      else count_reg = v[6:0];
    endfunction

    function logic [31:0] bump(logic [31:0] c);
      return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    // spike: update totals, bin every in-window lag, push into own ring
    function bit add_spike(int ch, logic [31:0] now);
      longint unsigned w, win, lag;
      int start, slot, b;
      logic [31:0] old;
      bit ovf;
      w = (width_reg == 16'd0) ? 64'd1 : 64'(width_reg);
      win = w * 64'((count_reg > 7'(NBINS)) ? 7'(NBINS) : count_reg);
      ovf = 0;
      if (!any_spike) begin
        t_first = now;
        any_spike = 1;
      end
      t_last = now;
      totals[ch] = bump(totals[ch]);
      for (int r = 0; r < NCH; r++) begin
        start = (head[r] + DEPTH - fill[r]) % DEPTH;
        for (int k = 0; k < fill[r]; k++) begin
          slot = (start + k) % DEPTH;
          old = ring_times[r*DEPTH + slot];
          if (old > now) continue;
          lag = 64'(now - old);
          if (lag < win) begin
            b = int'(lag / w);
            hist_cnt[(r*NCH + ch)*NBINS + b] = bump(hist_cnt[(r*NCH + ch)*NBINS + b]);
          end
        end
      end
      if (fill[ch] >= DEPTH) begin
        old = ring_times[ch*DEPTH + head[ch]];
        if (old <= now && 64'(now - old) < win) ovf = 1;
      end else begin
        fill[ch]++;
      end
      ring_times[ch*DEPTH + head[ch]] = now;
      head[ch] = (head[ch] + 1) % DEPTH;
      return ovf;
    endfunction

    function void note_beat(scc_in_t b);
      scc_out_t e;
      e = '0;
      case (b.action)
        ACT_SPIKE: e.ring_overflow = add_spike(int'(b.channel), b.spike_time);
        ACT_BIN:   e.value = hist_cnt[(b.ref_channel*NCH + b.channel)*NBINS + b.bin_index];
        ACT_TOTAL: e.value = totals[b.channel];
        default:   e.value = any_spike ? t_last - t_first : 32'd0;
      endcase
      owed.push_back(e);
    endfunction

    function void check_beat(scc_out_t got);
      scc_out_t e;
      if (owed.size() == 0) begin
        $error("unexpected result beat value=%h", got.value);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (got.value !== e.value) begin
        $error("value: expected %h, got %h", e.value, got.value);
        errors++;
      end
      if (got.ring_overflow !== e.ring_overflow) begin
        $error("ring_overflow: expected %b, got %b", e.ring_overflow, got.ring_overflow);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_stall, out_valid, out_stall;
  scc_in_t     in_data;
  scc_out_t    out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  spike_cross_correlogram dut (.*);

  correlogram_sb sb;
  int          send_idle_pct, recv_idle_pct;
  bit          hold_off;
  int          quiet_cycles;
  logic [31:0] clock_now;  // running spike timestamp

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // receiver: random stall, plus a long hold-off on request
  int hold_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_off && hold_left == 0) begin
      hold_left <= 3000;
      out_stall <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      hold_left <= 0;
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result check on every accepted beat
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_beat(out_data);
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("spike_cross_correlogram test failed");
      $finish;
    end
  end

  // offer one beat and wait for acceptance; random gaps before it
  task automatic send_beat(scc_in_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_beat(b);
  endtask

  task automatic end_beats();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // idle write: drain, let a trailing item finish, then write
  task automatic write_reg(logic idx, logic [15:0] v);
    end_beats();
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  function automatic scc_in_t mk(action_t a, int ch, logic [31:0] t, int rc, int bi);
    scc_in_t b;
    b.action = a;
    b.channel = 6'(ch);
    b.spike_time = t;
    b.ref_channel = 6'(rc);
    b.bin_index = 6'(bi);
    return b;
  endfunction

  // spikes on nch channels in mostly small time steps so lags land in-window; else reads
  task automatic random_beat(int nch);
    int pick;
    scc_in_t b;
    pick = $urandom_range(99);
    b = mk(ACT_SPIKE, $urandom_range(nch-1), $urandom, $urandom_range(nch-1),
           $urandom_range(NBINS-1));
    if (pick < 50) begin
      if ($urandom_range(19) == 0) clock_now = clock_now + $urandom;
      else clock_now = clock_now + $urandom_range(6);
      b.spike_time = clock_now;
      if ($urandom_range(29) == 0) b.spike_time = $urandom;  // out of order
    end else if (pick < 75) begin
      b.action = ACT_BIN;
      if ($urandom_range(9) == 0) b.channel = 6'($urandom_range(NCH-1));
    end else if (pick < 88) begin
      b.action = ACT_TOTAL;
      b.channel = 6'($urandom_range(NCH-1));
    end else begin
      b.action = ACT_SPAN;
      b.channel = 6'($urandom);
    end
    send_beat(b);
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = CFG_BIN_WIDTH;
    cfg_wdata = '0;
    send_idle_pct = 36;
    recv_idle_pct = 75;
    hold_off = 0;
    clock_now = 32'd100;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: span before any spike, field extremes, overflow
    send_beat(mk(ACT_SPAN, 0, 0, 0, 0));
    send_beat(mk(ACT_TOTAL, 63, 0, 0, 0));
    send_beat(mk(ACT_SPIKE, 0, 32'h0, 63, 63));
    send_beat(mk(ACT_SPIKE, 63, 32'h5, 0, 0));
    send_beat(mk(ACT_SPIKE, 0, 32'h3F, 0, 0));
    send_beat(mk(ACT_SPIKE, 1, 32'h2, 0, 0));  // earlier than some stored times
    send_beat(mk(ACT_BIN, 63, 0, 0, 5));
    send_beat(mk(ACT_BIN, 0, 32'hFFFF_FFFF, 0, 63));
    send_beat(mk(ACT_TOTAL, 0, 0, 0, 0));
    for (int i = 0; i < 17; i++) send_beat(mk(ACT_SPIKE, 2, 32'h40 + i, 0, 0));
    send_beat(mk(ACT_SPIKE, 3, 32'hFFFF_FFFF, 0, 0));
    send_beat(mk(ACT_SPAN, 0, 0, 0, 0));
    send_beat(mk(ACT_BIN, 2, 0, 2, 1));
    send_beat(mk(ACT_BIN, 2, 0, 0, 0));

    // random phases through several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_BIN_WIDTH, 16'd0);
          write_reg(CFG_BIN_COUNT, 16'd127);
        end
        1: begin
          write_reg(CFG_BIN_WIDTH, 16'hFFFF);
          write_reg(CFG_BIN_COUNT, 16'd1);
        end
        2: begin
          write_reg(CFG_BIN_WIDTH, 16'd3);
          write_reg(CFG_BIN_COUNT, 16'd0);
        end
        3: begin
          write_reg(CFG_BIN_WIDTH, 16'd2);
          write_reg(CFG_BIN_COUNT, 16'd64);
          send_idle_pct = 75;
          recv_idle_pct = 36;
        end
        4: begin
          write_reg(CFG_BIN_WIDTH, 16'd1);
          write_reg(CFG_BIN_COUNT, 16'd33);
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_off <= 1'b1;  // long receiver stall while we keep sending
        end
        default: begin
          write_reg(CFG_BIN_WIDTH, 16'd5);
          write_reg(CFG_BIN_COUNT, 16'd16);
        end
      endcase
      if (ph == 4) begin
        @(posedge clk);
        hold_off <= 1'b0;
      end
      // every bit of the channel field exercised on some phases
      for (int i = 0; i < 92; i++) random_beat((ph % 2) ? 64 : 6);
    end

    end_beats();
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (sb.errors == 0)
      $display("spike_cross_correlogram test passed");
    else
      $display("spike_cross_correlogram test failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/scc_pkg.sv
rtl/core/scc_ram.sv
rtl/core/scc_lag_div.sv
rtl/core/spike_cross_correlogram.sv
rtl/core/scc_checker.sv
bench/tb_top.sv
